/* sv/kfmt_pkg.sv */
// Shared types for the key frequency max tracker.
// Holds the sequencer state encoding and the command opcodes.
// No dependencies.
package kfmt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        OP_INC   = 2'd0,
        OP_CHECK = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

endpackage

/* sv/key_frequency_max_tracker_top.sv */
// Key frequency max tracker: top level with the scan sequencer and datapath.
// Depends on kfmt_pkg and instantiates kfmt_ram for the key/count table.
//
// Usage: drive opcode and key and raise start while busy is low; the command
// transfers at that edge. Opcodes: increment a key's count, check a key, or
// clear the table. Exactly one result follows each command: done is high for
// one cycle with count, is_max and status valid in that cycle.
// Increment and check scan the filled entries one per cycle through the
// single RAM read port, ending early on a hit; clear, the unused opcode and a
// command on an empty table go straight to the result. busy drops in the cycle
// done is shown, so the next command may transfer there.
// Entries fill in order from index 0; a fill count marks the live region, so
// reset and clear take effect at once with no sweep over the RAM.
// Reset (rst_n low) empties the table and zeroes the highest count.
// The receiver cannot stall: each result is taken in its strobe cycle.
module key_frequency_max_tracker_top
    import kfmt_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [KEY_BITS-1:0] key,
    output logic                done,
    output logic [31:0]         count,
    output logic                is_max,
    output logic                status
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam int ENT_W  = KEY_BITS + COUNT_BITS;

    state_t                state_reg, state_next;
    opcode_t               op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [COUNT_BITS-1:0] highest_reg, highest_next;
    logic [USED_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [31:0]           count_reg, count_next;
    logic                  is_max_reg, is_max_next;
    logic                  status_reg, status_next;

    logic                  ram_we;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ENT_W-1:0]      ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  issue;
    logic                  match;
    logic                  full;

    kfmt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[ENT_W-1 -: KEY_BITS];
    assign rd_cnt    = ram_rdata[COUNT_BITS-1:0];
    assign ram_wdata = {key_reg, cnt_reg};
    assign issue     = (rd_idx_reg < used_reg);
    assign match     = cmp_vld_reg && (rd_key == key_reg);
    assign full      = (used_reg == USED_W'(ENTRIES));

    // Write back on a hit or an insert of a new key during increment.
    assign ram_we = (state_reg == ST_FINISH) && (op_reg == OP_INC) && (hit_reg || !full);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        used_next    = used_reg;
        highest_next = highest_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        hit_next     = hit_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        is_max_next  = is_max_reg;
        status_next  = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = opcode_t'(opcode);
                    key_next    = key;
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    idx_next    = used_reg[IDX_W-1:0];
                    cnt_next    = COUNT_BITS'(1);
                    if ((opcode_t'(opcode) == OP_INC || opcode_t'(opcode) == OP_CHECK)
                        && used_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one read and compare the previous one each cycle.
                if (issue)
                begin
                    rd_idx_next  = rd_idx_reg + USED_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    hit_next   = 1'b1;
                    idx_next   = cmp_idx_reg;
                    state_next = ST_FINISH;
                    if (op_reg == OP_INC && rd_cnt != '1)
                    begin
                        cnt_next = rd_cnt + COUNT_BITS'(1);
                    end
                    else
                    begin
                        cnt_next = rd_cnt;
                    end
                end
                else if (!issue)
                begin
                    // Miss: insert point stays at the fill count.
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                count_next  = '0;
                is_max_next = 1'b0;
                status_next = 1'b0;
                case (op_reg)
                    OP_INC:
                    begin
                        if (hit_reg || !full)
                        begin
                            if (!hit_reg)
                            begin
                                used_next = used_reg + USED_W'(1);
                            end
                            if (cnt_reg > highest_reg)
                            begin
                                highest_next = cnt_reg;
                            end
                            count_next  = 32'(cnt_reg);
                            is_max_next = (cnt_reg >= highest_reg);
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    OP_CHECK:
                    begin
                        if (hit_reg)
                        begin
                            count_next  = 32'(cnt_reg);
                            is_max_next = (cnt_reg == highest_reg);
                        end
                    end
                    OP_CLEAR:
                    begin
                        used_next    = '0;
                        highest_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            highest_reg <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            highest_reg <= highest_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        count_reg   <= count_next;
        is_max_reg  <= is_max_next;
        status_reg  <= status_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign count  = count_reg;
    assign is_max = is_max_reg;
    assign status = status_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(ENTRIES))
        else $error("fill count beyond table depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |=> done)
        else $error("finish did not produce a result");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (!is_max && count == '0))
        else $error("dropped key reported a count");

    a_cmp_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cmp_vld_reg) |-> (USED_W'(cmp_idx_reg) < used_reg))
        else $error("compare outside filled region");

endmodule

/* sv/kfmt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module kfmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sim/tb_key_frequency_max_tracker_top.sv */
// Testbench for key_frequency_max_tracker_top: a directed run, then random table phases.
// Uses kfmt_pkg for opcodes and an in-bench tally table to predict every result.
// Needs only the RTL under sv/.
module tb_key_frequency_max_tracker_top;
    import kfmt_pkg::*;

    localparam int ENTRIES       = 64;
    localparam int KEY_BITS      = 32;
    localparam int COUNT_BITS    = 32;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int SETTLE_CYCLES = ENTRIES + 8;

    logic                clk    = 1'b0;
    logic                rst_n  = 1'b0;
    logic                start  = 1'b0;
    logic [1:0]          opcode = OP_INC;
    logic [KEY_BITS-1:0] key    = '0;
    logic                busy;
    logic                done;
    logic [31:0]         count;
    logic                is_max;
    logic                status;

    key_frequency_max_tracker_top #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .opcode(opcode),
        .key   (key),
        .done  (done),
        .count (count),
        .is_max(is_max),
        .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    class tally_scoreboard;
        typedef struct {
            logic [31:0] count;
            logic        is_max;
            logic        status;
        } tally_t;

        logic [KEY_BITS-1:0]   key_slot [ENTRIES];
        logic [COUNT_BITS-1:0] count_slot [ENTRIES];
        int unsigned           fill;
        logic [COUNT_BITS-1:0] peak_count;
        tally_t                expected_tallies [$];
        int unsigned           errors;

        function new();
            fill       = 0;
            peak_count = '0;
            errors     = 0;
        endfunction

        function int find_slot(logic [KEY_BITS-1:0] k);
            for (int i = 0; i < fill; i++)
            begin
                if (key_slot[i] == k)
                    return i;
            end
            return -1;
        endfunction

        // Apply one transferred command to the tally table and queue its result.
        function void note_command(logic [1:0] op, logic [KEY_BITS-1:0] k);
            tally_t t;
            int     slot;
            t.count  = '0;
            t.is_max = 1'b0;
            t.status = 1'b0;
            case (opcode_t'(op))
                OP_INC:
                begin
                    slot = find_slot(k);
                    if (slot >= 0)
                    begin
                        // hold at the counter maximum
                        if (count_slot[slot] != '1)
                            count_slot[slot] = count_slot[slot] + 1'b1;
                        t.count = count_slot[slot];
                    end
                    else if (fill < ENTRIES)
                    begin
                        key_slot[fill]   = k;
                        count_slot[fill] = 1;
                        fill++;
                        t.count = 1;
                    end
                    else
                        t.status = 1'b1;
                    if (!t.status)
                    begin
                        if (t.count > peak_count)
                            peak_count = t.count;
                        t.is_max = (t.count == peak_count);
                    end
                end
                OP_CHECK:
                begin
                    slot = find_slot(k);
                    if (slot >= 0)
                    begin
                        t.count  = count_slot[slot];
                        t.is_max = (count_slot[slot] == peak_count);
                    end
                end
                OP_CLEAR:
                begin
                    fill       = 0;
                    peak_count = '0;
                end
                default:
                    ;
            endcase
            expected_tallies.push_back(t);
        endfunction

        function void check_tally(logic [31:0] c, logic m, logic s);
            tally_t t;
            if (expected_tallies.size() == 0)
            begin
                $error("result with nothing pending: count %0d is_max %0b status %0b", c, m, s);
                errors++;
                return;
            end
            t = expected_tallies.pop_front();
            if (c !== t.count)
            begin
                $error("count: expected %0d, got %0d", t.count, c);
                errors++;
            end
            if (m !== t.is_max)
            begin
                $error("is_max: expected %0b, got %0b", t.is_max, m);
                errors++;
            end
            if (s !== t.status)
            begin
                $error("status: expected %0b, got %0b", t.status, s);
                errors++;
            end
        endfunction
    endclass

    tally_scoreboard tally_sb = new();
    int              burst_left = 0;
    int              items_sent = 0;

    always @(posedge clk)
    begin
        if (rst_n && done)
            tally_sb.check_tally(count, is_max, status);
    end

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Present one command and return at the edge where it transfers; start stays high.
    task automatic issue(logic [1:0] op, logic [KEY_BITS-1:0] k);
        start  <= 1'b1;
        opcode <= op;
        key    <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tally_sb.note_command(op, k);
        items_sent++;
    endtask

    // Send in bursts; a long gap now and then spans a whole scan.
    task automatic paced_issue(logic [1:0] op, logic [KEY_BITS-1:0] k);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, ENTRIES + 6)
                                              : $urandom_range(1, 4);
            idle_cycles(gap);
        end
        burst_left--;
        issue(op, k);
    endtask

    // One table lifetime: draw keys mostly from a pool so hits and a full table occur.
    task automatic run_phase(int pool_size, int phase_len);
        logic [KEY_BITS-1:0] pool [];
        int                  r;
        logic [1:0]          op;
        logic [KEY_BITS-1:0] k;
        pool = new[pool_size];
        foreach (pool[i])
        begin
            case ($urandom_range(0, 15))
                0:       pool[i] = '0;
                1:       pool[i] = '1;
                default: pool[i] = $urandom;
            endcase
        end
        for (int n = 0; n < phase_len; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                op = OP_INC;
            else if (r < 95)
                op = OP_CHECK;
            else if (r < 98)
                op = OP_NONE;
            else
                op = OP_CLEAR;
            r = $urandom_range(0, 13);
            if (r < 2)
                k = $urandom;
            else if (r < 8)
                k = pool[$urandom_range(0, pool_size - 1)];
            else
                k = pool[$urandom_range(0, $urandom_range(0, pool_size - 1))];
            paced_issue(op, k);
        end
        paced_issue(OP_CLEAR, $urandom);
    endtask

    initial
    begin
        int kind;
        int drain;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused opcode, then a few keys at the ends of the range
        issue(OP_CHECK, '0);
        issue(OP_CLEAR, '1);
        issue(OP_NONE, 32'h1234_5678);
        issue(OP_INC, '0);
        issue(OP_INC, '1);
        idle_cycles(3);
        issue(OP_INC, '0);
        issue(OP_CHECK, '1);
        issue(OP_CHECK, '0);
        issue(OP_CHECK, 32'h1234_5678);
        issue(OP_INC, '1);
        issue(OP_INC, '1);
        idle_cycles(1);
        issue(OP_INC, '0);
        issue(OP_INC, 32'hAAAA_AAAA);
        issue(OP_INC, 32'h5555_5555);
        issue(OP_CHECK, 32'hAAAA_AAAA);
        issue(OP_NONE, '0);
        issue(OP_CLEAR, '0);
        issue(OP_CHECK, '0);
        issue(OP_INC, '0);
        issue(OP_CHECK, '0);

        items_sent = 0;
        kind = 2;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (kind)
                0:       run_phase($urandom_range(1, 8), $urandom_range(20, 80));
                1:       run_phase($urandom_range(9, 60), $urandom_range(60, 200));
                default: run_phase($urandom_range(70, 130), $urandom_range(200, 350));
            endcase
            kind = $urandom_range(0, 2);
        end
        start <= 1'b0;

        drain = 0;
        while (tally_sb.expected_tallies.size() != 0 && drain < 10 * SETTLE_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tally_sb.expected_tallies.size() != 0)
            $error("%0d results never arrived", tally_sb.expected_tallies.size());
        if (tally_sb.errors == 0 && tally_sb.expected_tallies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
